/* sv/mtbl_pkg.sv */
package mtbl_pkg;

   localparam int QUERY_WIDTH     = 16;
   localparam int INDEX_WIDTH     = 8;
   localparam int ENTRY_WIDTH     = 16;
   localparam int VALUE_WIDTH     = 24;
   localparam int LOW_INDEX_WIDTH = 4;
   localparam int FRAC_BITS       = 8;

   typedef enum logic [1:0] {
      FN_LOOKUP  = 2'd0,
      FN_WR_X    = 2'd1,
      FN_WR_Y    = 2'd2,
      FN_WR_GRID = 2'd3
   } mtbl_func_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_X_ORDER = 2'd1,
      STAT_Y_ORDER = 2'd2,
      STAT_RANGE   = 2'd3
   } mtbl_status_type;

   typedef struct packed {
      mtbl_func_type            func;
      logic [QUERY_WIDTH-1:0]   x_query;
      logic [QUERY_WIDTH-1:0]   y_query;
      logic [INDEX_WIDTH-1:0]   entry_index;
      logic [ENTRY_WIDTH-1:0]   entry_value;
   } mtbl_req_type;

   typedef struct packed {
      mtbl_status_type              status;
      logic [VALUE_WIDTH-1:0]       value_q8;
      logic [LOW_INDEX_WIDTH-1:0]   x_low_index;
      logic [LOW_INDEX_WIDTH-1:0]   y_low_index;
   } mtbl_rsp_type;

   typedef struct packed {
      logic done;
      logic fail;
   } mtbl_scan_stat_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FETCH,
      S_CALC,
      S_RESP
   } mtbl_state_type;

   typedef enum logic [2:0] {
      AR_IDLE,
      AR_MUL,
      AR_AREA,
      AR_LAST,
      AR_DIV
   } mtbl_ar_state_type;

   typedef enum logic [2:0] {
      TAG_NONE,
      TAG_P1,
      TAG_LO,
      TAG_HI,
      TAG_AREA
   } mtbl_tag_type;

endpackage

/* sv/mtbl_ram.sv */
module mtbl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/mtbl_scan.sv */
module mtbl_scan #(
   parameter int TABLE_DIM  = 16,
   parameter int AXIS_WIDTH = 16,
   localparam int IW = $clog2(TABLE_DIM)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mtbl_pkg::QUERY_WIDTH-1:0]   query,
   input  logic [AXIS_WIDTH-1:0]              rdata,
   output logic [IW-1:0]                      raddr,
   output mtbl_pkg::mtbl_scan_stat_type       stat,
   output logic [IW-1:0]                      low_idx,
   output logic [AXIS_WIDTH-1:0]              lo_val,
   output logic [AXIS_WIDTH-1:0]              hi_val,
   output logic [AXIS_WIDTH-1:0]              clip_val
);

   localparam int CNW  = IW + 1;
   localparam int CMPW = (AXIS_WIDTH > mtbl_pkg::QUERY_WIDTH) ? AXIS_WIDTH
                                                             : mtbl_pkg::QUERY_WIDTH;
   localparam logic [CNW-1:0] CNT_END = CNW'(TABLE_DIM);
   localparam logic [IW-1:0]  LAST    = IW'(TABLE_DIM - 1);

   logic [CNW-1:0]        cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  vld_ff, vld_in;
   logic [IW-1:0]         k_ff, k_in;
   logic [AXIS_WIDTH-1:0] prev_ff, prev_in;
   logic                  fail_ff, fail_in;
   logic                  done_ff, done_in;
   logic [IW-1:0]         low_ff, low_in;
   logic [AXIS_WIDTH-1:0] lo_ff, lo_in;
   logic [AXIS_WIDTH-1:0] hi_ff, hi_in;
   logic [AXIS_WIDTH-1:0] clip_ff, clip_in;
   logic [CMPW-1:0]       qe, de, pe;

   assign qe = CMPW'(query);
   assign de = CMPW'(rdata);
   assign pe = CMPW'(prev_ff);

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      vld_in  = 1'b0;
      k_in    = k_ff;
      prev_in = prev_ff;
      fail_in = fail_ff;
      done_in = 1'b0;
      low_in  = low_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      clip_in = clip_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         fail_in = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_END) begin
            busy_in = 1'b0;
         end else begin
            vld_in = 1'b1;
            k_in   = cnt_ff[IW-1:0];
            cnt_in = cnt_ff + CNW'(1);
         end
      end
      if (vld_ff) begin
         prev_in = rdata;
         if (k_ff == '0) begin
            clip_in = (qe < de) ? rdata : AXIS_WIDTH'(query);
         end else begin
            if (pe >= de) begin
               fail_in = 1'b1;
            end
            if (k_ff == IW'(1)) begin
               low_in = '0;
               lo_in  = prev_ff;
               hi_in  = rdata;
            end
            if ((pe < qe) && (qe <= de)) begin
               low_in = k_ff - IW'(1);
               lo_in  = prev_ff;
               hi_in  = rdata;
            end
            if (k_ff == LAST) begin
               done_in = 1'b1;
               if (qe > de) begin
                  clip_in = rdata;
                  low_in  = LAST - IW'(1);
                  lo_in   = prev_ff;
                  hi_in   = rdata;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
         done_ff <= 1'b0;
         fail_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
         done_ff <= done_in;
         fail_ff <= fail_in;
      end
      k_ff    <= k_in;
      prev_ff <= prev_in;
      low_ff  <= low_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      clip_ff <= clip_in;
   end

   assign raddr     = cnt_ff[IW-1:0];
   assign stat.done = done_ff;
   assign stat.fail = fail_ff;
   assign low_idx   = low_ff;
   assign lo_val    = lo_ff;
   assign hi_val    = hi_ff;
   assign clip_val  = clip_ff;

endmodule

/* sv/mtbl_arith.sv */
module mtbl_arith #(
   parameter int AXIS_WIDTH = 16,
   parameter int CELL_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [3:0][CELL_WIDTH-1:0]         cells,
   input  logic [AXIS_WIDTH-1:0]              wx_lo,
   input  logic [AXIS_WIDTH-1:0]              wx_hi,
   input  logic [AXIS_WIDTH-1:0]              wy_lo,
   input  logic [AXIS_WIDTH-1:0]              wy_hi,
   input  logic [AXIS_WIDTH-1:0]              dx,
   input  logic [AXIS_WIDTH-1:0]              dy,
   output logic                               done,
   output logic [mtbl_pkg::VALUE_WIDTH-1:0]   quot
);

   localparam int MW   = (AXIS_WIDTH > CELL_WIDTH) ? AXIS_WIDTH : CELL_WIDTH;
   localparam int PW   = 2 * MW;
   localparam int ACW  = 3 * MW + 2;
   localparam int NW   = ACW + mtbl_pkg::FRAC_BITS;
   localparam int QW   = CELL_WIDTH + mtbl_pkg::FRAC_BITS;
   localparam int QBW  = (QW > mtbl_pkg::VALUE_WIDTH) ? QW : mtbl_pkg::VALUE_WIDTH;
   localparam int DCW  = $clog2(QW);

   mtbl_pkg::mtbl_ar_state_type state_ff, state_in;
   mtbl_pkg::mtbl_tag_type      tag_ff, tag_in;
   logic [1:0]      term_ff, term_in;
   logic [1:0]      sub_ff, sub_in;
   logic [PW-1:0]   mp_ff, mp_in;
   logic [MW-1:0]   phi_ff, phi_in;
   logic [ACW-1:0]  acc_ff, acc_in;
   logic [NW-1:0]   rem_ff, rem_in;
   logic [NW-1:0]   dv_ff, dv_in;
   logic [QBW-1:0]  q_ff, q_in;
   logic [DCW-1:0]  dcnt_ff, dcnt_in;
   logic            done_ff, done_in;
   logic [MW-1:0]   op_a, op_b;
   logic [CELL_WIDTH-1:0] cell_sel;
   logic [AXIS_WIDTH-1:0] wx_sel, wy_sel;
   logic            ge;
   logic            div_last;

   assign cell_sel = cells[term_ff];
   assign wx_sel   = term_ff[0] ? wx_hi : wx_lo;
   assign wy_sel   = term_ff[1] ? wy_hi : wy_lo;
   assign ge       = (rem_ff >= dv_ff);
   assign div_last = (dcnt_ff == DCW'(QW - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtbl_pkg::AR_IDLE: begin
            if (start) state_in = mtbl_pkg::AR_MUL;
         end
         mtbl_pkg::AR_MUL: begin
            if ((term_ff == 2'd3) && (sub_ff == 2'd2)) state_in = mtbl_pkg::AR_AREA;
         end
         mtbl_pkg::AR_AREA: state_in = mtbl_pkg::AR_LAST;
         mtbl_pkg::AR_LAST: state_in = mtbl_pkg::AR_DIV;
         mtbl_pkg::AR_DIV: begin
            if (div_last) state_in = mtbl_pkg::AR_IDLE;
         end
         default: state_in = mtbl_pkg::AR_IDLE;
      endcase
   end

   always_comb begin
      op_a   = '0;
      op_b   = '0;
      tag_in = mtbl_pkg::TAG_NONE;
      case (state_ff)
         mtbl_pkg::AR_MUL: begin
            case (sub_ff)
               2'd0: begin
                  op_a   = MW'(cell_sel);
                  op_b   = MW'(wx_sel);
                  tag_in = mtbl_pkg::TAG_P1;
               end
               2'd1: begin
                  op_a   = mp_ff[MW-1:0];
                  op_b   = MW'(wy_sel);
                  tag_in = mtbl_pkg::TAG_LO;
               end
               2'd2: begin
                  op_a   = phi_ff;
                  op_b   = MW'(wy_sel);
                  tag_in = mtbl_pkg::TAG_HI;
               end
               default: tag_in = mtbl_pkg::TAG_NONE;
            endcase
         end
         mtbl_pkg::AR_AREA: begin
            op_a   = MW'(dx);
            op_b   = MW'(dy);
            tag_in = mtbl_pkg::TAG_AREA;
         end
         default: tag_in = mtbl_pkg::TAG_NONE;
      endcase
   end

   always_comb begin
      term_in = term_ff;
      sub_in  = sub_ff;
      mp_in   = PW'(op_a) * PW'(op_b);
      phi_in  = phi_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      q_in    = q_ff;
      dcnt_in = dcnt_ff;
      done_in = 1'b0;
      if (start) begin
         term_in = '0;
         sub_in  = '0;
         acc_in  = '0;
      end else begin
         if (state_ff == mtbl_pkg::AR_MUL) begin
            if (sub_ff == 2'd2) begin
               sub_in  = '0;
               term_in = term_ff + 2'd1;
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
         case (tag_ff)
            mtbl_pkg::TAG_P1: phi_in = mp_ff[PW-1:MW];
            mtbl_pkg::TAG_LO: acc_in = acc_ff + ACW'(mp_ff);
            mtbl_pkg::TAG_HI: acc_in = acc_ff + (ACW'(mp_ff) << MW);
            default: acc_in = acc_ff;
         endcase
      end
      if (state_ff == mtbl_pkg::AR_LAST) begin
         dv_in   = NW'(mp_ff) << (QW - 1);
         rem_in  = NW'(acc_ff) << mtbl_pkg::FRAC_BITS;
         q_in    = '0;
         dcnt_in = '0;
      end
      if (state_ff == mtbl_pkg::AR_DIV) begin
         rem_in  = ge ? (rem_ff - dv_ff) : rem_ff;
         q_in    = {q_ff[QBW-2:0], ge};
         dv_in   = dv_ff >> 1;
         dcnt_in = dcnt_ff + DCW'(1);
         done_in = div_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtbl_pkg::AR_IDLE;
         tag_ff   <= mtbl_pkg::TAG_NONE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
         done_ff  <= done_in;
      end
      term_ff <= term_in;
      sub_ff  <= sub_in;
      mp_ff   <= mp_in;
      phi_ff  <= phi_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      q_ff    <= q_in;
      dcnt_ff <= dcnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff[mtbl_pkg::VALUE_WIDTH-1:0];

endmodule

/* sv/map_table_bilinear_lookup_top.sv */
// Two-dimensional calibration map: X and Y breakpoint axes of TABLE_DIM entries and a
// TABLE_DIM x TABLE_DIM grid of Z cells, loaded one entry per write item, answered by
// bilinear lookup items with 8 fraction bits. A lookup runs as a sequence: one pass over
// both axis memories checks ordering and finds the bracket (an ordering fault ends the
// lookup there), four grid reads follow, then a single shared multiplier runs thirteen
// products and a restoring divider retires one quotient bit per cycle. The block takes
// one item at a time; a finished result held in the output register does not block the
// next item. After reset the axis memories and the grid are cleared to zero before the
// first item is taken.
module map_table_bilinear_lookup_top #(
   parameter int TABLE_DIM  = 16,
   parameter int AXIS_WIDTH = 16,
   parameter int CELL_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mtbl_pkg::mtbl_req_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mtbl_pkg::mtbl_rsp_type  rsp_data
);

   localparam int IW         = $clog2(TABLE_DIM);
   localparam int GRID_DEPTH = TABLE_DIM * TABLE_DIM;
   localparam int GW         = $clog2(GRID_DEPTH);

   mtbl_pkg::mtbl_state_type state_ff, state_in;
   logic [GW-1:0]   clr_ff, clr_in;
   logic [mtbl_pkg::QUERY_WIDTH-1:0] xq_ff, xq_in, yq_ff, yq_in;
   logic            scan_start_ff, scan_start_in;
   logic [2:0]      f_ff, f_in;
   logic [3:0][CELL_WIDTH-1:0] cells_ff, cells_in;
   logic            ar_start_ff, ar_start_in;
   mtbl_pkg::mtbl_rsp_type pend_ff, pend_in;
   mtbl_pkg::mtbl_rsp_type rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            accept, is_lookup, axis_ok, grid_ok, clearing, load_rsp;
   logic            x_we, y_we, g_we;
   logic [IW-1:0]   ax_waddr;
   logic [AXIS_WIDTH-1:0] ax_wdata;
   logic [GW-1:0]   g_waddr, g_raddr, g_base, g_off;
   logic [CELL_WIDTH-1:0] g_wdata, g_rdata;
   logic [IW-1:0]   x_raddr, y_raddr;
   logic [AXIS_WIDTH-1:0] x_rdata, y_rdata;
   mtbl_pkg::mtbl_scan_stat_type x_stat, y_stat;
   logic [IW-1:0]   x_low, y_low;
   logic [AXIS_WIDTH-1:0] x_lo, x_hi, x_clip, y_lo, y_hi, y_clip;
   logic            ar_done;
   logic [mtbl_pkg::VALUE_WIDTH-1:0] ar_quot;

   assign accept    = req_valid && req_ready;
   assign is_lookup = (req_data.func == mtbl_pkg::FN_LOOKUP);
   assign axis_ok   = (32'(req_data.entry_index) < 32'(TABLE_DIM));
   assign grid_ok   = (32'(req_data.entry_index) < 32'(GRID_DEPTH));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtbl_pkg::S_CLEAR: begin
            if (clr_ff == GW'(GRID_DEPTH - 1)) state_in = mtbl_pkg::S_IDLE;
         end
         mtbl_pkg::S_IDLE: begin
            if (accept) state_in = is_lookup ? mtbl_pkg::S_SCAN : mtbl_pkg::S_RESP;
         end
         mtbl_pkg::S_SCAN: begin
            if (x_stat.done) begin
               state_in = (x_stat.fail || y_stat.fail) ? mtbl_pkg::S_RESP : mtbl_pkg::S_FETCH;
            end
         end
         mtbl_pkg::S_FETCH: begin
            if (f_ff == 3'd4) state_in = mtbl_pkg::S_CALC;
         end
         mtbl_pkg::S_CALC: begin
            if (ar_done) state_in = mtbl_pkg::S_RESP;
         end
         mtbl_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = mtbl_pkg::S_IDLE;
         end
         default: state_in = mtbl_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == mtbl_pkg::S_IDLE);
      clearing  = (state_ff == mtbl_pkg::S_CLEAR);
      load_rsp  = (state_ff == mtbl_pkg::S_RESP) && (!rsp_valid_ff || rsp_ready);
      x_we      = clearing ? (clr_ff < GW'(TABLE_DIM))
                           : (accept && (req_data.func == mtbl_pkg::FN_WR_X) && axis_ok);
      y_we      = clearing ? (clr_ff < GW'(TABLE_DIM))
                           : (accept && (req_data.func == mtbl_pkg::FN_WR_Y) && axis_ok);
      g_we      = clearing || (accept && (req_data.func == mtbl_pkg::FN_WR_GRID) && grid_ok);
      ax_waddr  = clearing ? clr_ff[IW-1:0] : IW'(req_data.entry_index);
      ax_wdata  = clearing ? '0 : AXIS_WIDTH'(req_data.entry_value);
      g_waddr   = clearing ? clr_ff : GW'(req_data.entry_index);
      g_wdata   = clearing ? '0 : CELL_WIDTH'(req_data.entry_value);
   end

   assign g_base  = GW'(GW'(y_low) * GW'(TABLE_DIM)) + GW'(x_low);
   assign g_off   = (f_ff[1] ? GW'(TABLE_DIM) : '0) + (f_ff[0] ? GW'(1) : '0);
   assign g_raddr = g_base + g_off;

   always_comb begin
      clr_in        = clearing ? (clr_ff + GW'(1)) : clr_ff;
      scan_start_in = accept && is_lookup;
      xq_in         = accept ? req_data.x_query : xq_ff;
      yq_in         = accept ? req_data.y_query : yq_ff;
      f_in          = (state_ff == mtbl_pkg::S_FETCH) ? (f_ff + 3'd1) : '0;
      cells_in      = cells_ff;
      for (int j = 0; j < 4; j++) begin
         if ((state_ff == mtbl_pkg::S_FETCH) && (f_ff == 3'(j + 1))) begin
            cells_in[j] = g_rdata;
         end
      end
      ar_start_in = (state_ff == mtbl_pkg::S_FETCH) && (f_ff == 3'd4);
      pend_in     = pend_ff;
      if (accept && !is_lookup) begin
         pend_in = '0;
         if (req_data.func == mtbl_pkg::FN_WR_GRID) begin
            pend_in.status = grid_ok ? mtbl_pkg::STAT_OK : mtbl_pkg::STAT_RANGE;
         end else begin
            pend_in.status = axis_ok ? mtbl_pkg::STAT_OK : mtbl_pkg::STAT_RANGE;
         end
      end
      if ((state_ff == mtbl_pkg::S_SCAN) && x_stat.done) begin
         pend_in        = '0;
         pend_in.status = x_stat.fail ? mtbl_pkg::STAT_X_ORDER
                        : (y_stat.fail ? mtbl_pkg::STAT_Y_ORDER : mtbl_pkg::STAT_OK);
      end
      if ((state_ff == mtbl_pkg::S_CALC) && ar_done) begin
         pend_in.status      = mtbl_pkg::STAT_OK;
         pend_in.value_q8    = ar_quot;
         pend_in.x_low_index = mtbl_pkg::LOW_INDEX_WIDTH'(x_low);
         pend_in.y_low_index = mtbl_pkg::LOW_INDEX_WIDTH'(y_low);
      end
      rsp_data_in  = load_rsp ? pend_ff : rsp_data_ff;
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mtbl_pkg::S_CLEAR;
         clr_ff        <= '0;
         scan_start_ff <= 1'b0;
         ar_start_ff   <= 1'b0;
         f_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         scan_start_ff <= scan_start_in;
         ar_start_ff   <= ar_start_in;
         f_ff          <= f_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      xq_ff       <= xq_in;
      yq_ff       <= yq_in;
      cells_ff    <= cells_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   mtbl_ram #(.WIDTH(AXIS_WIDTH), .DEPTH(TABLE_DIM)) u_x_ram (
      .clock (clock),
      .we    (x_we),
      .waddr (ax_waddr),
      .wdata (ax_wdata),
      .raddr (x_raddr),
      .rdata (x_rdata)
   );

   mtbl_ram #(.WIDTH(AXIS_WIDTH), .DEPTH(TABLE_DIM)) u_y_ram (
      .clock (clock),
      .we    (y_we),
      .waddr (ax_waddr),
      .wdata (ax_wdata),
      .raddr (y_raddr),
      .rdata (y_rdata)
   );

   mtbl_ram #(.WIDTH(CELL_WIDTH), .DEPTH(GRID_DEPTH)) u_grid_ram (
      .clock (clock),
      .we    (g_we),
      .waddr (g_waddr),
      .wdata (g_wdata),
      .raddr (g_raddr),
      .rdata (g_rdata)
   );

   mtbl_scan #(.TABLE_DIM(TABLE_DIM), .AXIS_WIDTH(AXIS_WIDTH)) u_x_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start_ff),
      .query    (xq_ff),
      .rdata    (x_rdata),
      .raddr    (x_raddr),
      .stat     (x_stat),
      .low_idx  (x_low),
      .lo_val   (x_lo),
      .hi_val   (x_hi),
      .clip_val (x_clip)
   );

   mtbl_scan #(.TABLE_DIM(TABLE_DIM), .AXIS_WIDTH(AXIS_WIDTH)) u_y_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start_ff),
      .query    (yq_ff),
      .rdata    (y_rdata),
      .raddr    (y_raddr),
      .stat     (y_stat),
      .low_idx  (y_low),
      .lo_val   (y_lo),
      .hi_val   (y_hi),
      .clip_val (y_clip)
   );

   mtbl_arith #(.AXIS_WIDTH(AXIS_WIDTH), .CELL_WIDTH(CELL_WIDTH)) u_arith (
      .clock (clock),
      .reset (reset),
      .start (ar_start_ff),
      .cells (cells_ff),
      .wx_lo (x_hi - x_clip),
      .wx_hi (x_clip - x_lo),
      .wy_lo (y_hi - y_clip),
      .wy_hi (y_clip - y_lo),
      .dx    (x_hi - x_lo),
      .dy    (y_hi - y_lo),
      .done  (ar_done),
      .quot  (ar_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/mtbl_checker.sv */
module mtbl_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input mtbl_pkg::mtbl_req_type  req_data,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input mtbl_pkg::mtbl_rsp_type  rsp_data
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while previous item in progress");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != mtbl_pkg::STAT_OK) |->
         (rsp_data.value_q8 == '0) && (rsp_data.x_low_index == '0) &&
         (rsp_data.y_low_index == '0))
      else $error("error result carries nonzero fields");

endmodule

bind map_table_bilinear_lookup_top mtbl_checker u_mtbl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* verif/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM = 16;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mtbl_pkg::mtbl_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   mtbl_pkg::mtbl_rsp_type rsp_data;

   map_table_bilinear_lookup_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   logic [15:0] x_bp [DIM];
   logic [15:0] y_bp [DIM];
   logic [15:0] cells [DIM*DIM];
   int unsigned x_hint, y_hint;
   mtbl_pkg::mtbl_rsp_type pending_rsp [$];
   int fail_count = 0;
   longint unsigned cycles = 0;

   typedef struct {
      mtbl_pkg::mtbl_req_type req;
      bit                     typed;
      mtbl_pkg::mtbl_rsp_type rsp;
   } vec_row_type;
   vec_row_type vectors [$];

   function automatic bit is_rising(ref logic [15:0] ax [DIM]);
      for (int i = 0; i + 1 < DIM; i++)
         if (ax[i] >= ax[i+1]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned bracket(ref logic [15:0] ax [DIM], input logic [15:0] q,
                                           inout int unsigned hint);
      int unsigned u;
      u = (hint > 0 && hint < DIM) ? hint : 1;
      if (q < ax[u] && q > ax[u-1]) begin
      end else if (q > ax[u] && u + 1 < DIM && q < ax[u+1]) begin
         u++;
      end else if (q < ax[u-1] && u > 1 && q > ax[u-2]) begin
         u--;
      end else begin
         u = 1;
         for (int i = DIM - 1; i >= 1; i--)
            if (q <= ax[i] && q > ax[i-1]) begin
               u = i;
               break;
            end
      end
      hint = u;
      return u;
   endfunction

   function automatic mtbl_pkg::mtbl_rsp_type predict_map(mtbl_pkg::mtbl_req_type r);
      mtbl_pkg::mtbl_rsp_type o;
      logic [15:0] xq, yq;
      int unsigned xu, yu;
      logic [127:0] sum, area;
      logic [63:0] x0, x1, y0, y1;
      o = '0;
      o.status = mtbl_pkg::STAT_OK;
      case (r.func)
         mtbl_pkg::FN_WR_X, mtbl_pkg::FN_WR_Y: begin
            if (r.entry_index >= DIM) o.status = mtbl_pkg::STAT_RANGE;
            else if (r.func == mtbl_pkg::FN_WR_X) x_bp[r.entry_index] = r.entry_value;
            else y_bp[r.entry_index] = r.entry_value;
         end
         mtbl_pkg::FN_WR_GRID: cells[r.entry_index] = r.entry_value;
         default: begin
            if (!is_rising(x_bp)) begin
               o.status = mtbl_pkg::STAT_X_ORDER;
               return o;
            end
            xq = r.x_query;
            if (xq > x_bp[DIM-1]) xq = x_bp[DIM-1];
            if (xq < x_bp[0]) xq = x_bp[0];
            xu = bracket(x_bp, xq, x_hint);
            if (!is_rising(y_bp)) begin
               o.status = mtbl_pkg::STAT_Y_ORDER;
               return o;
            end
            yq = r.y_query;
            if (yq > y_bp[DIM-1]) yq = y_bp[DIM-1];
            if (yq < y_bp[0]) yq = y_bp[0];
            yu = bracket(y_bp, yq, y_hint);
            x0 = x_bp[xu-1]; x1 = x_bp[xu];
            y0 = y_bp[yu-1]; y1 = y_bp[yu];
            sum = 128'(cells[(yu-1)*DIM + xu-1]) * (x1 - xq) * (y1 - yq)
                + 128'(cells[(yu-1)*DIM + xu]) * (xq - x0) * (y1 - yq)
                + 128'(cells[yu*DIM + xu-1]) * (x1 - xq) * (yq - y0)
                + 128'(cells[yu*DIM + xu]) * (xq - x0) * (yq - y0);
            area = 128'((x1 - x0) * (y1 - y0));
            o.value_q8 = 24'((sum << 8) / area);
            o.x_low_index = 4'(xu - 1);
            o.y_low_index = 4'(yu - 1);
         end
      endcase
      return o;
   endfunction

   function automatic mtbl_pkg::mtbl_req_type make_req(mtbl_pkg::mtbl_func_type f, int xq,
                                                       int yq, int idx, int v);
      mtbl_pkg::mtbl_req_type r;
      r.func = f;
      r.x_query = 16'(xq);
      r.y_query = 16'(yq);
      r.entry_index = 8'(idx);
      r.entry_value = 16'(v);
      return r;
   endfunction

   task automatic add_row(mtbl_pkg::mtbl_req_type r, bit typed = 1'b0,
                          mtbl_pkg::mtbl_status_type st = mtbl_pkg::STAT_OK);
      vec_row_type v;
      v.req = r;
      v.typed = typed;
      v.rsp = '0;
      v.rsp.status = st;
      vectors.push_back(v);
   endtask

   task automatic send_item(mtbl_pkg::mtbl_req_type r, bit typed,
                            mtbl_pkg::mtbl_rsp_type want);
      mtbl_pkg::mtbl_rsp_type p;
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
            (($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 3));
      repeat (gap) @(posedge clock);
      p = predict_map(r);
      if (typed && p !== want) begin
         $display("%0t table row disagrees: expected %h actual %h", $time, want, p);
         fail_count++;
      end
      pending_rsp.push_back(p);
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
   endtask

   task automatic drain_all();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_axis(mtbl_pkg::mtbl_func_type f, int base, int stepmax);
      int v;
      v = base;
      for (int i = 0; i < DIM; i++) begin
         send_item(make_req(f, $urandom, $urandom, i, v), 1'b0, '0);
         v += $urandom_range(1, stepmax);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected item: actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            if (rsp_data !== pending_rsp[0]) begin
               $display("%0t mismatch: expected %h actual %h", $time, pending_rsp[0],
                        rsp_data);
               fail_count++;
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) rsp_ready <= 1'b0;
      else if (r < 40) rsp_ready <= $urandom_range(0, 1);
      else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      mtbl_pkg::mtbl_rsp_type none;
      int kind, span, n_items;
      none = '0;
      foreach (x_bp[i]) begin
         x_bp[i] = '0;
         y_bp[i] = '0;
      end
      foreach (cells[i]) cells[i] = '0;
      x_hint = 0;
      y_hint = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      add_row(make_req(mtbl_pkg::FN_LOOKUP, 16'hFFFF, 16'hFFFF, 0, 0), 1'b1,
              mtbl_pkg::STAT_X_ORDER);
      add_row(make_req(mtbl_pkg::FN_WR_X, 0, 0, 16, 16'hFFFF), 1'b1, mtbl_pkg::STAT_RANGE);
      add_row(make_req(mtbl_pkg::FN_WR_Y, 0, 0, 255, 16'hFFFF), 1'b1, mtbl_pkg::STAT_RANGE);
      add_row(make_req(mtbl_pkg::FN_WR_GRID, 0, 0, 255, 16'hFFFF), 1'b1, mtbl_pkg::STAT_OK);
      add_row(make_req(mtbl_pkg::FN_WR_GRID, 0, 0, 0, 16'hFFFF), 1'b1, mtbl_pkg::STAT_OK);
      for (int i = 0; i < DIM; i++)
         add_row(make_req(mtbl_pkg::FN_WR_X, 0, 0, i, i * 4096 + (i == 15 ? 4095 : 0)),
                 1'b1);
      add_row(make_req(mtbl_pkg::FN_LOOKUP, 0, 0, 0, 0), 1'b1, mtbl_pkg::STAT_Y_ORDER);
      foreach (vectors[i]) send_item(vectors[i].req, vectors[i].typed, vectors[i].rsp);
      drain_all();
      repeat (100) @(posedge clock);

      write_axis(mtbl_pkg::FN_WR_Y, 0, 4369);
      send_item(make_req(mtbl_pkg::FN_LOOKUP, 0, 0, 0, 0), 1'b0, none);
      send_item(make_req(mtbl_pkg::FN_LOOKUP, 16'hFFFF, 16'hFFFF, 0, 0), 1'b0, none);
      send_item(make_req(mtbl_pkg::FN_LOOKUP, 4096, 8192, 0, 0), 1'b0, none);
      send_item(make_req(mtbl_pkg::FN_LOOKUP, 4097, 1, 0, 0), 1'b0, none);
      drain_all();

      n_items = 0;
      while (n_items < 1850) begin
         kind = $urandom_range(0, 99);
         if (kind < 4) begin
            span = $urandom_range(0, 2);
            write_axis(mtbl_pkg::FN_WR_X, $urandom_range(0, 200),
                       span == 0 ? 3 : (span == 1 ? 300 : 4369));
            write_axis(mtbl_pkg::FN_WR_Y, $urandom_range(0, 200),
                       span == 2 ? 3 : (span == 1 ? 300 : 4369));
            n_items += 32;
         end else if (kind < 6) begin
            send_item(make_req(mtbl_pkg::mtbl_func_type'($urandom_range(1, 2)), 0, 0,
                               $urandom_range(0, 255), $urandom), 1'b0, none);
            n_items++;
         end else if (kind < 30) begin
            send_item(make_req(mtbl_pkg::FN_WR_GRID, 0, 0, $urandom_range(0, 255),
                               $urandom), 1'b0, none);
            n_items++;
         end else begin
            if ($urandom_range(0, 1))
               send_item(make_req(mtbl_pkg::FN_LOOKUP, $urandom, $urandom, $urandom,
                                  $urandom), 1'b0, none);
            else
               send_item(make_req(mtbl_pkg::FN_LOOKUP, x_bp[$urandom_range(0, DIM-1)]
                                  + $urandom_range(0, 2) - 1,
                                  y_bp[$urandom_range(0, DIM-1)], 0, 0), 1'b0, none);
            n_items++;
         end
         if ($urandom_range(0, 299) == 0) drain_all();
      end
      drain_all();
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end
endmodule

/* sim.f */
sv/mtbl_pkg.sv
sv/mtbl_ram.sv
sv/mtbl_scan.sv
sv/mtbl_arith.sv
sv/map_table_bilinear_lookup_top.sv
sv/mtbl_checker.sv
verif/tb.sv
